### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sha1mh_pkg.sv
// ---------------------------------------------------------------------------
// sha1mh_pkg
// Types and constants of the SHA-1 message hasher.
// ---------------------------------------------------------------------------
package sha1mh_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int BLOCK_BITS  = 512;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] IV_E = 32'hC3D2E1F0;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic [31:0] digest_e;
  } out_item_t;

  // full block offered from the packer to the round engine
  typedef struct packed {
    logic valid;
    logic last;
  } blk_req_t;

endpackage

### hdl/sha1mh_fifo.sv
// ---------------------------------------------------------------------------
// sha1mh_fifo
// Short item queue between the input port and the block packer.
// ---------------------------------------------------------------------------
module sha1mh_fifo #(
  parameter int DEPTH = sha1mh_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_stall,
  input  sha1mh_pkg::in_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_take,
  output sha1mh_pkg::in_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha1mh_pkg::in_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          wr_en;
  logic          rd_en;

  assign wr_stall = (cnt == CW'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_item  = slots[rd_ptr];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

### hdl/sha1mh_pad.sv
// ---------------------------------------------------------------------------
// sha1mh_pad
// Packs message bytes big-endian into 64-byte blocks and appends padding
// and the 64-bit bit length at end of message.
// ---------------------------------------------------------------------------
module sha1mh_pad (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  q_take,
  input  sha1mh_pkg::in_item_t                  q_item,
  output sha1mh_pkg::blk_req_t                  blk,
  output logic [sha1mh_pkg::BLOCK_BITS-1:0]     blk_data,
  input  logic                                  blk_take
);

  typedef enum logic [1:0] {
    S_DATA,
    S_ZERO,
    S_LEN
  } state_t;

  state_t       state;
  logic [5:0]   pos;
  logic [2:0]   len_idx;
  logic [60:0]  msg_bytes;
  logic         full;
  logic         full_last;
  logic [sha1mh_pkg::BLOCK_BITS-1:0] blk_buf;

  logic         push;
  logic [7:0]   push_byte;
  logic [63:0]  len_bits;

  assign len_bits     = {msg_bytes, 3'b000};
  assign blk          = '{valid: full, last: full_last};
  assign blk_data     = blk_buf;

  always_comb begin
    q_take    = 1'b0;
    push      = 1'b0;
    push_byte = q_item.data_byte;
    unique case (state)
      S_DATA: begin
        if (q_valid && !full) begin
          q_take = 1'b1;
          push   = 1'b1;
          if (q_item.kind == sha1mh_pkg::KIND_END) begin
            push_byte = sha1mh_pkg::PAD_BYTE;
          end
        end
      end
      S_ZERO: begin
        push_byte = 8'h00;
        push      = !full && (pos != 6'd56);
      end
      S_LEN: begin
        push_byte = len_bits[{~len_idx, 3'b000} +: 8];
        push      = !full;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      blk_buf <= {blk_buf[sha1mh_pkg::BLOCK_BITS-9:0], push_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_DATA;
      pos       <= '0;
      len_idx   <= '0;
      msg_bytes <= '0;
      full      <= 1'b0;
      full_last <= 1'b0;
    end else begin
      if (blk_take) begin
        full <= 1'b0;
      end
      if (push) begin
        pos <= pos + 1'b1;
        if (pos == 6'd63) begin
          full      <= 1'b1;
          full_last <= (state == S_LEN);
        end
      end
      unique case (state)
        S_DATA: begin
          if (q_take) begin
            if (q_item.kind == sha1mh_pkg::KIND_END) begin
              state <= S_ZERO;
            end else begin
              msg_bytes <= msg_bytes + 1'b1;
            end
          end
        end
        S_ZERO: begin
          if (pos == 6'd56) begin
            state   <= S_LEN;
            len_idx <= '0;
          end
        end
        S_LEN: begin
          if (push) begin
            len_idx <= len_idx + 1'b1;
            if (len_idx == 3'd7) begin
              state     <= S_DATA;
              msg_bytes <= '0;
            end
          end
        end
        default: begin
          state <= S_DATA;
        end
      endcase
    end
  end

endmodule

### hdl/sha1mh_core.sv
// ---------------------------------------------------------------------------
// sha1mh_core
// SHA-1 round engine: one round per cycle with a 16-word rolling schedule,
// chaining words, and the digest output register.
// ---------------------------------------------------------------------------
module sha1mh_core (
  input  logic                               clk,
  input  logic                               rst,
  input  sha1mh_pkg::blk_req_t               blk,
  input  logic [sha1mh_pkg::BLOCK_BITS-1:0]  blk_data,
  output logic                               blk_take,
  output logic                               digest_valid,
  input  logic                               digest_stall,
  output sha1mh_pkg::out_item_t              digest
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_DONE
  } state_t;

  state_t      state;
  logic [6:0]  rnd;
  logic        last;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h0, h1, h2, h3, h4;

  logic [31:0] f;
  logic [31:0] kc;
  logic [31:0] t;
  logic [31:0] w_new;
  logic [31:0] s0, s1, s2, s3, s4;
  logic        out_free;
  logic        emit;

  assign blk_take = (state == C_IDLE) && blk.valid;
  assign out_free = !digest_valid || !digest_stall;
  assign emit     = (state == C_DONE) && last && out_free;

  always_comb begin
    if (rnd < 7'd20) begin
      f  = (b & c) | (~b & d);
      kc = sha1mh_pkg::K_0;
    end else if (rnd < 7'd40) begin
      f  = b ^ c ^ d;
      kc = sha1mh_pkg::K_1;
    end else if (rnd < 7'd60) begin
      f  = (b & c) | (b & d) | (c & d);
      kc = sha1mh_pkg::K_2;
    end else begin
      f  = b ^ c ^ d;
      kc = sha1mh_pkg::K_3;
    end
  end

  assign t     = {a[26:0], a[31:27]} + f + e + w[0] + kc;
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  assign s0 = h0 + a;
  assign s1 = h1 + b;
  assign s2 = h2 + c;
  assign s3 = h3 + d;
  assign s4 = h4 + e;

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (state == C_IDLE && blk.valid) begin
      for (int k = 0; k < 16; k++) begin
        w[k] <= blk_data[sha1mh_pkg::BLOCK_BITS-1-32*k -: 32];
      end
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (state == C_ROUND) begin
      for (int k = 0; k < 15; k++) begin
        w[k] <= w[k+1];
      end
      w[15] <= w_new;
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= C_IDLE;
      rnd          <= '0;
      last         <= 1'b0;
      digest_valid <= 1'b0;
      h0           <= sha1mh_pkg::IV_A;
      h1           <= sha1mh_pkg::IV_B;
      h2           <= sha1mh_pkg::IV_C;
      h3           <= sha1mh_pkg::IV_D;
      h4           <= sha1mh_pkg::IV_E;
    end else begin
      if (emit) begin
        digest_valid <= 1'b1;
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        C_IDLE: begin
          if (blk.valid) begin
            state <= C_ROUND;
            rnd   <= '0;
            last  <= blk.last;
          end
        end
        C_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 7'd79) begin
            state <= C_DONE;
          end
        end
        C_DONE: begin
          if (!last) begin
            h0    <= s0;
            h1    <= s1;
            h2    <= s2;
            h3    <= s3;
            h4    <= s4;
            state <= C_IDLE;
          end else if (out_free) begin
            digest       <= '{digest_a: s0, digest_b: s1, digest_c: s2,
                              digest_d: s3, digest_e: s4};
            h0           <= sha1mh_pkg::IV_A;
            h1           <= sha1mh_pkg::IV_B;
            h2           <= sha1mh_pkg::IV_C;
            h3           <= sha1mh_pkg::IV_D;
            h4           <= sha1mh_pkg::IV_E;
            state        <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/sha1_message_hasher.sv
// ---------------------------------------------------------------------------
// sha1_message_hasher
// SHA-1 over a byte stream, one digest per end-of-message item.
// ---------------------------------------------------------------------------
// Items enter a short queue, so the input keeps taking bytes while a block
// is compressed. The packer shifts one byte per cycle into a 64-byte block
// buffer while that buffer is not full; the round engine runs one round per
// cycle, and the next block fills while it runs. A steady byte stream is
// therefore limited by the round engine. An end item adds the padding bytes
// (up to 64 plus 8 length bytes) and one or two compressions before the
// digest appears in the output register.
module sha1_message_hasher #(
  parameter int QUEUE_DEPTH = sha1mh_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  sha1mh_pkg::in_item_t  item,
  output logic                  digest_valid,
  input  logic                  digest_stall,
  output sha1mh_pkg::out_item_t digest
);

  logic                              q_valid;
  logic                              q_take;
  sha1mh_pkg::in_item_t              q_item;
  sha1mh_pkg::blk_req_t              blk;
  logic [sha1mh_pkg::BLOCK_BITS-1:0] blk_data;
  logic                              blk_take;

  sha1mh_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (item_valid),
    .wr_stall (item_stall),
    .wr_item  (item),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_item  (q_item)
  );

  sha1mh_pad u_pad (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item),
    .blk      (blk),
    .blk_data (blk_data),
    .blk_take (blk_take)
  );

  sha1mh_core u_core (
    .clk          (clk),
    .rst          (rst),
    .blk          (blk),
    .blk_data     (blk_data),
    .blk_take     (blk_take),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

### hdl/sha1mh_checker.sv
// ---------------------------------------------------------------------------
// sha1mh_checker
// Port-level checks of the SHA-1 message hasher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1mh_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input sha1mh_pkg::in_item_t  item,
  input logic                  digest_valid,
  input logic                  digest_stall,
  input sha1mh_pkg::out_item_t digest
);

  logic [7:0] pending;
  logic       end_acc;
  logic       dig_acc;

  assign end_acc = item_valid && !item_stall && (item.kind == sha1mh_pkg::KIND_END);
  assign dig_acc = digest_valid && !digest_stall;

  // end items taken whose digest is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({end_acc, dig_acc})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  `ASSERT_CLK(a_digest_hold, digest_valid && digest_stall |=> digest_valid && $stable(digest), "digest changed while stalled")
  `ASSERT_CLK(a_digest_owed, digest_valid |-> pending != 8'd0, "digest without an end item")
  `ASSERT_CLK_NR(a_reset_quiet, rst |=> !digest_valid, "digest valid after reset")
  `ASSERT_CLK_NR(a_reset_ready, rst |=> !item_stall, "input stalled after reset")

endmodule

bind sha1_message_hasher sha1mh_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .digest_valid (digest_valid),
  .digest_stall (digest_stall),
  .digest       (digest)
);

### sim/tb_sha1_message_hasher.sv
// ---------------------------------------------------------------------------
// tb_sha1_message_hasher
// Self-checking bench: byte messages in, SHA-1 digests checked against a
// local model, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_sha1_message_hasher;

  class sha1_scoreboard;
    logic [31:0]           chain [5];
    logic [7:0]            block [64];
    logic [60:0]           byte_count;
    sha1mh_pkg::out_item_t expected_digests [$];
    int                    errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0]   = sha1mh_pkg::IV_A;
      chain[1]   = sha1mh_pkg::IV_B;
      chain[2]   = sha1mh_pkg::IV_C;
      chain[3]   = sha1mh_pkg::IV_D;
      chain[4]   = sha1mh_pkg::IV_E;
      byte_count = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, kc, t, mix;
      int          slot;
      for (int k = 0; k < 16; k++) begin
        w[k] = {block[4*k], block[4*k+1], block[4*k+2], block[4*k+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        slot = r & 15;
        if (r >= 16) begin
          mix = w[(slot+13)&15] ^ w[(slot+8)&15] ^ w[(slot+2)&15] ^ w[slot];
          w[slot] = {mix[30:0], mix[31]};
        end
        if (r < 20) begin
          f  = (b & c) | (~b & d);
          kc = sha1mh_pkg::K_0;
        end else if (r < 40) begin
          f  = b ^ c ^ d;
          kc = sha1mh_pkg::K_1;
        end else if (r < 60) begin
          f  = (b & c) | (b & d) | (c & d);
          kc = sha1mh_pkg::K_2;
        end else begin
          f  = b ^ c ^ d;
          kc = sha1mh_pkg::K_3;
        end
        t = {a[26:0], a[31:27]} + f + e + w[slot] + kc;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_item(sha1mh_pkg::in_item_t it);
      int                    pos;
      logic [63:0]           bit_len;
      sha1mh_pkg::out_item_t dig;
      pos = int'(byte_count[5:0]);
      if (it.kind == sha1mh_pkg::KIND_DATA) begin
        block[pos] = it.data_byte;
        byte_count = byte_count + 1'b1;
        if (byte_count[5:0] == 6'd0) compress();
      end else begin
        block[pos] = sha1mh_pkg::PAD_BYTE;
        pos++;
        if (pos > 56) begin
          while (pos < 64) begin
            block[pos] = 8'h00;
            pos++;
          end
          compress();
          pos = 0;
        end
        while (pos < 56) begin
          block[pos] = 8'h00;
          pos++;
        end
        bit_len = {byte_count, 3'b000};
        for (int k = 0; k < 8; k++) block[56+k] = bit_len[63-8*k -: 8];
        compress();
        dig.digest_a = chain[0];
        dig.digest_b = chain[1];
        dig.digest_c = chain[2];
        dig.digest_d = chain[3];
        dig.digest_e = chain[4];
        expected_digests.push_back(dig);
        restart();
      end
    endfunction

    function void check_digest(sha1mh_pkg::out_item_t got);
      sha1mh_pkg::out_item_t want;
      logic [31:0]           want_w [5];
      logic [31:0]           got_w [5];
      if (expected_digests.size() == 0) begin
        errors++;
        $display("%0t: digest %h arrived with none expected", $time, got);
      end else begin
        want   = expected_digests.pop_front();
        want_w = '{want.digest_a, want.digest_b, want.digest_c, want.digest_d, want.digest_e};
        got_w  = '{got.digest_a, got.digest_b, got.digest_c, got.digest_d, got.digest_e};
        for (int k = 0; k < 5; k++) begin
          if (got_w[k] !== want_w[k]) begin
            errors++;
            $display("%0t: digest word %0d expected %08h, got %08h",
                     $time, k, want_w[k], got_w[k]);
          end
        end
      end
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction

    function void final_check();
      if (expected_digests.size() != 0) begin
        errors++;
        $display("%0t: %0d digest(s) never arrived", $time, expected_digests.size());
      end
    endfunction
  endclass

  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN   = 2500;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  sha1mh_pkg::in_item_t  item = '0;
  logic                  digest_valid;
  logic                  digest_stall = 1'b0;
  sha1mh_pkg::out_item_t digest;

  sha1_scoreboard sb = new();

  int burst_left = 1;
  int gap_max = 0;
  int items_sent = 0;
  int ends_sent = 0;

  sha1_message_hasher i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) sb.check_digest(digest);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input sha1mh_pkg::in_item_t it);
    item_valid <= 1'b1;
    item       <= it;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    sha1mh_pkg::in_item_t it;
    it.kind      = sha1mh_pkg::KIND_DATA;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_end();
    sha1mh_pkg::in_item_t it;
    it.kind      = sha1mh_pkg::KIND_END;
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
    ends_sent++;
  endtask

  initial begin
    int len;
    int fill;
    int pick;
    logic [7:0] b;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_max = 3;
    send_end();
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_end();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_end();
    send_end();
    send_end();

    while (items_sent < 1200 || ends_sent < 20) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          case ($urandom_range(0, 9))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            7: len = 120;
            8: len = 127;
            default: len = 128;
          endcase
        end
        1: len = $urandom_range(129, 192);
        default: len = $urandom_range(0, 40);
      endcase
      fill    = $urandom_range(0, 9);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (fill == 0) b = 8'h00;
        else if (fill == 1) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        send_byte(b);
      end
      send_end();
    end

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: stall pattern is re-drawn at random; one long hold-off
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        cyc++;
        if (cyc % 200 == 0) mode = $urandom_range(0, 3);
        if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
          digest_stall <= 1'b1;
        end else begin
          case (mode)
            0: digest_stall <= 1'b0;
            1: digest_stall <= ($urandom_range(0, 2) == 0);
            2: digest_stall <= ($urandom_range(0, 3) != 0);
            default: digest_stall <= ((cyc % 5) < 2);
          endcase
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
